// ----- hw/rtl/gnc_pkg.sv -----
`timescale 1ns / 1ps
package gnc_pkg;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_QDIV   = 14'b00000000000010,
        S_MU0    = 14'b00000000000100,
        S_MUCHK  = 14'b00000000001000,
        S_MUDIV  = 14'b00000000010000,
        S_SCALE  = 14'b00000000100000,
        S_WRD    = 14'b00000001000000,
        S_WDIV   = 14'b00000010000000,
        S_WACC   = 14'b00000100000000,
        S_EMIT   = 14'b00001000000000,
        S_MSDIV  = 14'b00010000000000,
        S_SQRT   = 14'b00100000000000,
        S_SUMM   = 14'b01000000000000,
        S_MNDIV  = 14'b10000000000000
    } t_state;

    localparam logic [1:0] REG_SHAPE     = 2'd0;
    localparam logic [1:0] REG_DIVISOR   = 2'd1;
    localparam logic [1:0] REG_STAGES    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    localparam logic [39:0] Q40_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] MU_ONE  = 40'd256;
    localparam logic [16:0] W_ONE   = 17'd65536;

endpackage

// ----- hw/rtl/gnc_ram.sv -----
`timescale 1ns / 1ps
module gnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/gnc_robust_weight_evaluator_core.sv -----
`timescale 1ns / 1ps
// A residual request is taken when i_start is high and o_busy is low. Each stored pair runs
// one 128-step restoring division for its normalised square, with o_busy high until it is
// done; a pair with zero sigma or one beyond the store is not divided and marks the run
// invalid. The request marked last then runs the mu schedule (one division for the starting
// mu and one per further stage), one division per weight, one division for the weighted mean
// square, a 32-step square root and one division for the mean weight, the divisions all on
// the same shared divider, and then the summary. Weights appear on o_valid, and the
// receiver cannot stall them. A not-evaluated run yields only a summary.
module gnc_robust_weight_evaluator_core
    import gnc_pkg::*;
#(
    parameter int MAX_RESIDUALS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_residual_m,
    input  logic [30:0] i_sigma_m,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_kind,
    output logic [16:0] o_weight,
    output logic        o_evaluated,
    output logic [7:0]  o_stages,
    output logic [39:0] o_initial_mu,
    output logic [39:0] o_final_mu,
    output logic [16:0] o_min_weight,
    output logic [16:0] o_mean_weight,
    output logic [22:0] o_weight_sum,
    output logic [30:0] o_weighted_rms,
    output logic [5:0]  o_downweighted_count,
    output logic        o_last_res
);
    localparam int AW = (MAX_RESIDUALS > 1) ? $clog2(MAX_RESIDUALS) : 1;
    localparam int DEPTH = 1 << AW;

    t_state r_state;
    logic [15:0] r_shape, r_divisor;
    logic [7:0]  r_max_stages;
    logic [16:0] r_threshold;
    logic [5:0]  r_count;
    logic [39:0] r_max_q;
    logic        r_invalid;
    logic        r_last;
    logic [31:0] r_res;

    // Shared restoring divider: dividend shifts out MSB first.
    logic [127:0] r_dvd;
    logic [63:0]  r_dsr;
    logic [64:0]  r_rem;
    logic [63:0]  r_quo;
    logic         r_sat;
    logic [7:0]   r_step;
    logic [6:0]   r_qbits;

    logic [65:0] rem_sh;
    logic        ge;
    logic [64:0] rem_nx;
    assign rem_sh = {r_rem, r_dvd[127]};
    assign ge     = rem_sh >= {2'b0, r_dsr};
    assign rem_nx = ge ? 65'(rem_sh - {2'b0, r_dsr}) : rem_sh[64:0];

    logic [63:0] div_lim;
    assign div_lim = (r_qbits == 7'd64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                     64'(({64'b0, 1'b1} << r_qbits) - 65'd1);
    logic [63:0] div_res;
    assign div_res = r_sat ? div_lim : r_quo;

    logic [39:0] r_mu0, r_mu, r_applied;
    logic [7:0]  r_stg;
    logic [31:0] r_s2;
    logic [55:0] r_scale;
    logic [AW-1:0] r_idx;
    logic [5:0]  r_emit;
    logic [22:0] r_wsum;
    logic [16:0] r_wmin;
    logic [16:0] r_mean;
    logic [5:0]  r_down;
    logic [127:0] r_acc;
    logic [16:0] r_w;
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [1:0]  r_ph;

    logic           ram_we;
    logic [AW-1:0]  ram_wa, ram_ra;
    logic [31:0]    res_rd;
    logic [39:0]    q_rd;
    logic           w_we;
    logic [16:0]    w_rd;

    gnc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_res_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(r_res),
        .i_raddr(ram_ra), .o_rdata(res_rd));
    gnc_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_q_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(div_res[39:0]),
        .i_raddr(ram_ra), .o_rdata(q_rd));
    gnc_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_w_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_idx), .i_wdata(r_w),
        .i_raddr(r_emit[AW-1:0]), .o_rdata(w_rd));

    assign ram_wa = r_count[AW-1:0];
    assign ram_we = (r_state == S_QDIV) && (r_step == 8'd0);
    assign ram_ra = r_idx;
    assign w_we   = (r_state == S_WACC);

    logic [31:0] mag_in, mag_rd;
    assign mag_in = i_residual_m[31] ? 32'(-i_residual_m) : i_residual_m;
    assign mag_rd = res_rd[31] ? 32'(-res_rd) : res_rd;

    logic bad_run;
    assign bad_run = r_invalid || (r_count == 6'd0) || (r_shape == 16'd0) ||
                     (r_divisor <= 16'd256) || (r_max_stages == 8'd0) ||
                     (r_threshold > W_ONE);

    assign o_busy = (r_state != S_IDLE);

    logic [63:0] sq_tr;
    assign sq_tr = r_sq_res + r_sq_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_shape      <= 16'd256;
            r_divisor    <= 16'd358;
            r_max_stages <= 8'd100;
            r_threshold  <= 17'd32768;
            r_count      <= '0;
            r_max_q      <= '0;
            r_invalid    <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= ((r_state == S_EMIT) && (r_ph == 2'd1)) || (r_state == S_SUMM) ||
                       ((r_state == S_MU0) && r_last && bad_run);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SHAPE:     r_shape <= i_cfg_data[15:0];
                    REG_DIVISOR:   r_divisor <= i_cfg_data[15:0];
                    REG_STAGES:    r_max_stages <= i_cfg_data[7:0];
                    REG_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_QDIV || r_state == S_MUDIV || r_state == S_WDIV ||
                r_state == S_MSDIV || r_state == S_MNDIV) begin
                if (r_step != 8'd0) begin
                    r_rem  <= rem_nx;
                    r_dvd  <= {r_dvd[126:0], 1'b0};
                    r_step <= r_step - 8'd1;
                    if (ge) begin
                        if ((r_step - 8'd1) >= {1'b0, r_qbits}) r_sat <= 1'b1;
                        else r_quo[6'(r_step - 8'd1)] <= 1'b1;
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_last <= i_last;
                        r_res  <= i_residual_m;
                        if (i_sigma_m == 31'd0 || r_count >= 6'(MAX_RESIDUALS)) begin
                            r_invalid <= 1'b1;
                            r_state   <= S_MU0;
                        end else begin
                            r_dvd  <= {56'b0, 64'(mag_in) * 64'(mag_in), 8'b0};
                            r_dsr  <= 64'(i_sigma_m) * 64'(i_sigma_m);
                            r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                            r_step <= 8'd128; r_qbits <= 7'd40;
                            r_state <= S_QDIV;
                        end
                    end
                end
                S_QDIV: begin
                    if (r_step == 8'd0) begin
                        if (div_res[39:0] > r_max_q) r_max_q <= div_res[39:0];
                        r_count <= r_count + 6'd1;
                        r_state <= S_MU0;
                    end
                end
                S_MU0: begin
                    // Ends request; on last, emits bad-run summary or starts mu0 division.
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (bad_run) begin
                        o_kind <= 1'b1; o_weight <= '0;
                        o_evaluated <= 1'b0; o_stages <= '0; o_initial_mu <= '0;
                        o_final_mu <= '0; o_min_weight <= '0; o_mean_weight <= '0;
                        o_weight_sum <= '0; o_weighted_rms <= '0;
                        o_downweighted_count <= '0; o_last_res <= 1'b1;
                        r_count <= '0; r_max_q <= '0; r_invalid <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_s2   <= 32'(r_shape) * 32'(r_shape);
                        r_dvd  <= {72'b0, r_max_q, 16'b0};
                        r_dsr  <= 64'(32'(r_shape) * 32'(r_shape));
                        r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                        r_step <= 8'd128; r_qbits <= 7'd40;
                        r_stg <= '0;
                        r_ph <= 2'd0;
                        r_state <= S_MUDIV;
                    end
                end
                S_MUDIV: begin
                    if (r_step == 8'd0) begin
                        if (r_stg == 8'd0) begin
                            r_mu0 <= (div_res[39:0] < MU_ONE) ? MU_ONE : div_res[39:0];
                            r_mu  <= (div_res[39:0] < MU_ONE) ? MU_ONE : div_res[39:0];
                        end else begin
                            r_mu <= (div_res[39:0] < MU_ONE) ? MU_ONE : div_res[39:0];
                        end
                        r_state <= S_MUCHK;
                    end
                end
                S_MUCHK: begin
                    if (r_stg >= r_max_stages) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_applied <= r_mu;
                        r_stg <= r_stg + 8'd1;
                        if (r_mu <= MU_ONE) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_dvd <= {80'b0, r_mu, 8'b0};
                            r_dsr <= 64'(r_divisor);
                            r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                            r_step <= 8'd128; r_qbits <= 7'd64;
                            r_state <= S_MUDIV;
                        end
                    end
                end
                S_SCALE: begin
                    if (r_ph == 2'd0) begin
                        r_acc <= 128'(52'(r_applied[19:0]) * 52'(r_s2));
                        r_ph  <= 2'd1;
                    end else begin
                        r_scale <= 56'((72'(r_acc[51:0]) +
                                        (72'(52'(r_applied[39:20]) * 52'(r_s2)) << 20)) >> 16);
                        r_idx <= '0;
                        r_wsum <= '0; r_wmin <= W_ONE; r_down <= '0; r_acc <= '0;
                        r_ph <= 2'd0;
                        r_state <= S_WRD;
                    end
                end
                S_WRD: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        r_dvd <= {56'b0, r_scale, 16'b0};
                        r_dsr <= 64'(r_scale) + 64'(q_rd);
                        r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                        r_step <= 8'd128; r_qbits <= 7'd17;
                        r_state <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (r_step == 8'd0) begin
                        r_w <= (q_rd == 40'd0) ? W_ONE : div_res[16:0];
                        r_sq_v <= 64'(mag_rd) * 64'(mag_rd);
                        r_state <= S_WACC;
                    end
                end
                S_WACC: begin
                    r_wsum <= r_wsum + 23'(r_w);
                    if (r_w < r_wmin) r_wmin <= r_w;
                    if (r_w < r_threshold) r_down <= r_down + 6'd1;
                    r_acc <= r_acc + (128'(r_sq_v[63:32] * 49'(r_w)) << 32)
                                   + 128'(r_sq_v[31:0] * 49'(r_w));
                    if (6'(r_idx) + 6'd1 == r_count) begin
                        r_emit <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= S_WRD;
                    end
                end
                S_EMIT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        o_kind <= 1'b0;
                        o_weight <= w_rd;
                        o_evaluated <= 1'b1; o_stages <= '0; o_initial_mu <= '0;
                        o_final_mu <= '0; o_min_weight <= '0; o_mean_weight <= '0;
                        o_weight_sum <= '0; o_weighted_rms <= '0;
                        o_downweighted_count <= '0; o_last_res <= 1'b0;
                        r_emit <= r_emit + 6'd1;
                        if (r_emit + 6'd1 == r_count) begin
                            r_dvd <= r_acc;
                            r_dsr <= 64'(r_wsum);
                            r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                            r_step <= 8'd128; r_qbits <= 7'd64;
                            r_state <= S_MSDIV;
                        end
                    end
                end
                S_MSDIV: begin
                    if (r_step == 8'd0) begin
                        r_sq_v <= (r_wsum == 23'd0) ? 64'd0 : div_res;
                        r_sq_res <= '0;
                        r_sq_bit <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit == 64'd0) begin
                        r_dvd <= {105'b0, r_wsum};
                        r_dsr <= 64'(r_count);
                        r_rem <= '0; r_quo <= '0; r_sat <= 1'b0;
                        r_step <= 8'd128; r_qbits <= 7'd17;
                        r_state <= S_MNDIV;
                    end else begin
                        if (r_sq_v >= sq_tr) begin
                            r_sq_v <= r_sq_v - sq_tr;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_MNDIV: begin
                    if (r_step == 8'd0) begin
                        r_mean <= div_res[16:0];
                        r_state <= S_SUMM;
                    end
                end
                S_SUMM: begin
                    o_kind <= 1'b1; o_weight <= '0;
                    o_evaluated <= 1'b1; o_stages <= r_stg; o_initial_mu <= r_mu0;
                    o_final_mu <= r_applied; o_min_weight <= r_wmin;
                    o_mean_weight <= r_mean;
                    o_weight_sum <= r_wsum;
                    o_weighted_rms <= (r_sq_res > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF :
                                      r_sq_res[30:0];
                    o_downweighted_count <= r_down; o_last_res <= 1'b1;
                    r_count <= '0; r_max_q <= '0; r_invalid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_res) |-> o_busy) else $error("weight request while idle");
    a_count_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 6'(MAX_RESIDUALS)) else $error("item count overflow");
    a_summary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_res) |-> (r_count == 6'd0)) else $error("count not cleared");
`endif
endmodule
